/* design/pisp_pkg.sv */
`timescale 1ns / 1ps
package pisp_pkg;

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_F     = 8'h46;

  localparam logic [1:0] RADIX_DEC = 2'd0;
  localparam logic [1:0] RADIX_BIN = 2'd1;
  localparam logic [1:0] RADIX_OCT = 2'd2;
  localparam logic [1:0] RADIX_HEX = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_DIGIT = 2'd1;
  localparam logic [1:0] ST_BAD_CHAR = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  localparam int CHAR_W  = 8;
  localparam int VALUE_W = 32;
  localparam int POS_W   = 8;
  localparam int QDEPTH  = 2;

  localparam logic signed [37:0] INT_MAX_EXT = 38'sd2147483647;
  localparam logic signed [37:0] INT_MIN_EXT = -38'sd2147483648;

  typedef struct packed {
    logic       is_minus;
    logic       is_b;
    logic       is_zero;
    logic       is_x;
    logic       is_digit;
    logic [3:0] digit;
    logic       last;
  } pisp_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0]   error_position;
  } pisp_result_t;

endpackage

/* design/pisp_queue.sv */
`timescale 1ns / 1ps
module pisp_queue #(
  parameter int W
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_en,
  input  logic [W-1:0] wr_data,
  output logic         full,
  input  logic         rd_en,
  output logic [W-1:0] rd_data,
  output logic         empty
);
  import pisp_pkg::*;

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QDEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QDEPTH);

  logic [W-1:0]     mem_r [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign full    = (cnt_r == CNT_FULL);
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rd_ptr_r];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

/* design/pisp_front.sv */
`timescale 1ns / 1ps
module pisp_front (
  input  logic [pisp_pkg::CHAR_W-1:0] character,
  input  logic                        last,
  output pisp_pkg::pisp_item_t        item
);
  import pisp_pkg::*;

  logic is_dec, is_hex;

  assign is_dec = (character inside {[CH_ZERO:CH_NINE]});
  assign is_hex = (character inside {[CH_A:CH_F]});

  always_comb begin
    item.is_minus = (character == CH_MINUS);
    item.is_b     = (character == CH_B);
    item.is_zero  = (character == CH_ZERO);
    item.is_x     = (character == CH_X);
    item.is_digit = is_dec || is_hex;
    item.last     = last;
    if (is_dec) begin
      item.digit = 4'(character - CH_ZERO);
    end else if (is_hex) begin
      item.digit = 4'(character - CH_A + 8'd10);
    end else begin
      item.digit = 4'd0;
    end
  end

endmodule

/* design/pisp_back.sv */
`timescale 1ns / 1ps
module pisp_back #(
  parameter int IDX_LIMIT
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  pisp_pkg::pisp_item_t   item,
  input  logic                   item_valid,
  output logic                   item_take,
  output pisp_pkg::pisp_result_t result,
  output logic                   result_push,
  input  logic                   result_full
);
  import pisp_pkg::*;

  localparam int IDX_W = (IDX_LIMIT > 0) ? $clog2(IDX_LIMIT + 1) : 1;
  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(IDX_LIMIT);

  localparam logic [1:0] PH_START  = 2'd0;
  localparam logic [1:0] PH_PREFIX = 2'd1;
  localparam logic [1:0] PH_ZERO   = 2'd2;
  localparam logic [1:0] PH_DIGITS = 2'd3;

  logic [1:0]         phase_r, phase_nxt;
  logic               neg_r, neg_nxt;
  logic [1:0]         radix_r, radix_nxt;
  logic [VALUE_W-1:0] acc_r, acc_nxt;
  logic               seen_r, seen_nxt;
  logic               bad_r, bad_nxt;
  logic               ovf_r, ovf_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [IDX_W-1:0]   bad_idx_r, bad_idx_nxt;

  logic               pfx, take, valid;
  logic signed [37:0] acc_ext, prod, sum;

  assign item_take   = item_valid && !(item.last && result_full);
  assign result_push = item_take && item.last;
  assign acc_ext     = 38'(signed'(acc_r));

  always_comb begin
    phase_nxt   = phase_r;
    neg_nxt     = neg_r;
    radix_nxt   = radix_r;
    acc_nxt     = acc_r;
    seen_nxt    = seen_r;
    bad_nxt     = bad_r;
    ovf_nxt     = ovf_r;
    idx_nxt     = idx_r;
    bad_idx_nxt = bad_idx_r;
    pfx         = 1'b0;
    take        = 1'b0;
    valid       = 1'b0;
    prod        = '0;
    sum         = '0;

    case (phase_r)
      PH_START: begin
        if (item.is_minus) begin
          neg_nxt   = 1'b1;
          phase_nxt = PH_PREFIX;
        end else begin
          pfx = 1'b1;
        end
      end
      PH_PREFIX: begin
        pfx = 1'b1;
      end
      PH_ZERO: begin
        phase_nxt = PH_DIGITS;
        if (item.is_x) begin
          radix_nxt = RADIX_HEX;
          seen_nxt  = 1'b0;
        end else begin
          radix_nxt = RADIX_OCT;
          take      = 1'b1;
        end
      end
      default: begin
        take = 1'b1;
      end
    endcase

    if (pfx) begin
      if (item.is_b) begin
        radix_nxt = RADIX_BIN;
        phase_nxt = PH_DIGITS;
      end else if (item.is_zero) begin
        radix_nxt = RADIX_OCT;
        seen_nxt  = 1'b1;
        acc_nxt   = '0;
        phase_nxt = PH_ZERO;
      end else begin
        radix_nxt = RADIX_DEC;
        phase_nxt = PH_DIGITS;
        take      = 1'b1;
      end
    end

    case (radix_nxt)
      RADIX_BIN: begin
        valid = item.is_digit && (item.digit < 4'd2);
        prod  = acc_ext <<< 1;
      end
      RADIX_OCT: begin
        valid = item.is_digit && (item.digit < 4'd8);
        prod  = acc_ext <<< 3;
      end
      RADIX_HEX: begin
        valid = item.is_digit;
        prod  = acc_ext <<< 4;
      end
      default: begin
        valid = item.is_digit && (item.digit <= 4'd9);
        prod  = (acc_ext <<< 3) + (acc_ext <<< 1);
      end
    endcase
    sum = neg_nxt ? prod - 38'(item.digit) : prod + 38'(item.digit);

    if (take) begin
      if (!valid) begin
        if (!bad_r) begin
          bad_nxt     = 1'b1;
          bad_idx_nxt = idx_r;
        end
      end else begin
        seen_nxt = 1'b1;
        if (!bad_r && !ovf_r) begin
          if (sum > INT_MAX_EXT || sum < INT_MIN_EXT) begin
            ovf_nxt = 1'b1;
          end else begin
            acc_nxt = sum[VALUE_W-1:0];
          end
        end
      end
    end

    if (idx_r < IDX_MAX) begin
      idx_nxt = idx_r + 1'b1;
    end

    result.value          = '0;
    result.error_position = '0;
    if (bad_nxt) begin
      result.status         = ST_BAD_CHAR;
      result.error_position = POS_W'(bad_idx_nxt);
    end else if (!seen_nxt) begin
      result.status = ST_NO_DIGIT;
    end else if (ovf_nxt) begin
      result.status = ST_OVERFLOW;
    end else begin
      result.status = ST_OK;
      result.value  = acc_nxt;
    end

    if (item.last) begin
      phase_nxt   = PH_START;
      neg_nxt     = 1'b0;
      radix_nxt   = RADIX_DEC;
      acc_nxt     = '0;
      seen_nxt    = 1'b0;
      bad_nxt     = 1'b0;
      ovf_nxt     = 1'b0;
      idx_nxt     = '0;
      bad_idx_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_START;
      neg_r     <= 1'b0;
      radix_r   <= RADIX_DEC;
      acc_r     <= '0;
      seen_r    <= 1'b0;
      bad_r     <= 1'b0;
      ovf_r     <= 1'b0;
      idx_r     <= '0;
      bad_idx_r <= '0;
    end else if (item_take) begin
      phase_r   <= phase_nxt;
      neg_r     <= neg_nxt;
      radix_r   <= radix_nxt;
      acc_r     <= acc_nxt;
      seen_r    <= seen_nxt;
      bad_r     <= bad_nxt;
      ovf_r     <= ovf_nxt;
      idx_r     <= idx_nxt;
      bad_idx_r <= bad_idx_nxt;
    end
  end

`ifndef SYNTH
  // A finished string leaves the parser in its start state.
  a_reset_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    result_push |=> (phase_r == PH_START) && !bad_r && !ovf_r && !seen_r && (idx_r == '0))
    else $error("parser state not cleared after last beat");

  // Once overflow is flagged the accumulator holds until the string ends.
  a_acc_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    (ovf_r && !result_push) |=> $stable(acc_r))
    else $error("accumulator changed after overflow");

  // The first bad position never lies beyond the current index.
  a_bad_idx: assert property (@(posedge clk) disable iff (!rst_n)
    bad_r |-> (bad_idx_r <= idx_r))
    else $error("bad character index ahead of character index");

  // A binary or hex radix is only ever held in the digit-scanning phase.
  a_hex_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (radix_r == RADIX_HEX || radix_r == RADIX_BIN) |-> (phase_r == PH_DIGITS))
    else $error("binary or hex radix outside digit phase");
`endif

endmodule

/* design/prefixed_integer_string_parser.sv */
`timescale 1ns / 1ps
// Channel   Direction  Handshake             Fields
// in_       input      in_push / in_full     in_character[7:0], in_last
// out_      output     out_pop / out_empty   out_status[1:0], out_value[31:0],
//                                            out_error_position[7:0]
//
// One character beat is taken per cycle while in_full is low. A beat waits in
// the two-entry character queue, and the parser writes the result of a string
// straight into a two-entry result queue, whose head drives the out_ ports.
// Synchronous reset returns both queues to empty and the parser to the start
// of a string. A stalled result side blocks only beats with last set once the
// result queue is full; in_full rises when the character queue fills.
module prefixed_integer_string_parser #(
  parameter int MAX_LEN = 256
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_push,
  input  logic [pisp_pkg::CHAR_W-1:0]  in_character,
  input  logic                         in_last,
  output logic                         in_full,
  output logic                         out_empty,
  input  logic                         out_pop,
  output logic [1:0]                   out_status,
  output logic signed [pisp_pkg::VALUE_W-1:0] out_value,
  output logic [pisp_pkg::POS_W-1:0]   out_error_position
);
  import pisp_pkg::*;

  localparam int IDX_LIMIT = (MAX_LEN - 1 < 255) ? MAX_LEN - 1 : 255;
  localparam int ITEM_W    = $bits(pisp_item_t);
  localparam int RES_W     = $bits(pisp_result_t);

  pisp_item_t   cls_item, q_item;
  pisp_result_t res, q_res;
  logic         q_empty, item_take, res_push, res_full;

  pisp_front u_front (
    .character (in_character),
    .last      (in_last),
    .item      (cls_item)
  );

  pisp_queue #(.W(ITEM_W)) u_item_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_push),
    .wr_data (cls_item),
    .full    (in_full),
    .rd_en   (item_take),
    .rd_data (q_item),
    .empty   (q_empty)
  );

  pisp_back #(.IDX_LIMIT(IDX_LIMIT)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .item        (q_item),
    .item_valid  (!q_empty),
    .item_take   (item_take),
    .result      (res),
    .result_push (res_push),
    .result_full (res_full)
  );

  pisp_queue #(.W(RES_W)) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_data (res),
    .full    (res_full),
    .rd_en   (out_pop),
    .rd_data (q_res),
    .empty   (out_empty)
  );

  assign out_status         = q_res.status;
  assign out_value          = signed'(q_res.value);
  assign out_error_position = q_res.error_position;

endmodule

/* tb/sv/number_parse_checker.sv */
`timescale 1ns / 1ps
module number_parse_checker #(
  parameter int MAX_LEN = 256
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  input  logic                                in_full,
  input  logic [pisp_pkg::CHAR_W-1:0]         in_character,
  input  logic                                in_last,
  input  logic                                out_empty,
  input  logic                                out_pop,
  input  logic [1:0]                          out_status,
  input  logic signed [pisp_pkg::VALUE_W-1:0] out_value,
  input  logic [pisp_pkg::POS_W-1:0]          out_error_position,
  output int                                  mismatches,
  output int                                  pending
);
  import pisp_pkg::*;

  typedef enum logic [1:0] {
    SCAN_START,
    SCAN_SIGNED,
    SCAN_LEAD_ZERO,
    SCAN_DIGITS
  } scan_t;

  localparam int IDX_LIMIT = (MAX_LEN - 1 < 255) ? MAX_LEN - 1 : 255;

  scan_t              scan;
  logic               negative;
  logic [1:0]         radix;
  logic [VALUE_W-1:0] acc;
  logic               digit_seen;
  logic               bad_seen;
  logic               ovf_seen;
  logic [POS_W-1:0]   char_idx;
  logic [POS_W-1:0]   bad_idx;
  pisp_result_t       expected_results[$];

  function automatic int radix_base(input logic [1:0] r);
    case (r)
      RADIX_BIN: return 2;
      RADIX_OCT: return 8;
      RADIX_HEX: return 16;
      default:   return 10;
    endcase
  endfunction

  task automatic clear_parse();
    scan       = SCAN_START;
    negative   = 1'b0;
    radix      = RADIX_DEC;
    acc        = '0;
    digit_seen = 1'b0;
    bad_seen   = 1'b0;
    ovf_seen   = 1'b0;
    char_idx   = '0;
    bad_idx    = '0;
  endtask

  task automatic absorb_digit(input logic [7:0] c, input logic [POS_W-1:0] idx);
    int     base;
    int     d;
    bit     ok;
    longint sum;
    base = radix_base(radix);
    ok   = 1'b1;
    d    = 0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = int'(c - CH_ZERO);
    end else if (c >= CH_A && c <= CH_F) begin
      d = int'(c - CH_A) + 10;
    end else begin
      ok = 1'b0;
    end
    if (ok && d >= base) begin
      ok = 1'b0;
    end
    if (!ok) begin
      if (!bad_seen) begin
        bad_seen = 1'b1;
        bad_idx  = idx;
      end
      return;
    end
    digit_seen = 1'b1;
    if (bad_seen || ovf_seen) begin
      return;
    end
    sum = longint'($signed(acc)) * longint'(base);
    sum = negative ? sum - longint'(d) : sum + longint'(d);
    if (sum > 64'sd2147483647 || sum < -64'sd2147483648) begin
      ovf_seen = 1'b1;
    end else begin
      acc = sum[VALUE_W-1:0];
    end
  endtask

  task automatic choose_prefix(input logic [7:0] c, input logic [POS_W-1:0] idx);
    if (c == CH_B) begin
      radix = RADIX_BIN;
      scan  = SCAN_DIGITS;
    end else if (c == CH_ZERO) begin
      // The octal lead zero is itself a digit.
      radix      = RADIX_OCT;
      digit_seen = 1'b1;
      acc        = '0;
      scan       = SCAN_LEAD_ZERO;
    end else begin
      radix = RADIX_DEC;
      scan  = SCAN_DIGITS;
      absorb_digit(c, idx);
    end
  endtask

  task automatic scan_char(input logic [7:0] c, input logic last);
    logic [POS_W-1:0] idx;
    pisp_result_t     res;
    idx = char_idx;
    case (scan)
      SCAN_START: begin
        if (c == CH_MINUS) begin
          negative = 1'b1;
          scan     = SCAN_SIGNED;
        end else begin
          choose_prefix(c, idx);
        end
      end
      SCAN_SIGNED: begin
        choose_prefix(c, idx);
      end
      SCAN_LEAD_ZERO: begin
        if (c == CH_X) begin
          radix      = RADIX_HEX;
          digit_seen = 1'b0;
          scan       = SCAN_DIGITS;
        end else begin
          radix = RADIX_OCT;
          scan  = SCAN_DIGITS;
          absorb_digit(c, idx);
        end
      end
      default: begin
        absorb_digit(c, idx);
      end
    endcase
    if (int'(char_idx) < IDX_LIMIT) begin
      char_idx = char_idx + 1'b1;
    end
    if (last) begin
      res = '0;
      if (bad_seen) begin
        res.status         = ST_BAD_CHAR;
        res.error_position = bad_idx;
      end else if (!digit_seen) begin
        res.status = ST_NO_DIGIT;
      end else if (ovf_seen) begin
        res.status = ST_OVERFLOW;
      end else begin
        res.status = ST_OK;
        res.value  = acc;
      end
      expected_results.push_back(res);
      clear_parse();
    end
  endtask

  task automatic check_result();
    pisp_result_t want;
    if (expected_results.size() == 0) begin
      $error("status: expected none, actual %0d (result beat with nothing waiting)",
             out_status);
      mismatches = mismatches + 1;
      return;
    end
    want = expected_results.pop_front();
    if (out_status !== want.status) begin
      $error("status: expected %0d, actual %0d", want.status, out_status);
      mismatches = mismatches + 1;
    end
    if (out_value !== want.value) begin
      $error("value: expected %0d, actual %0d", $signed(want.value), out_value);
      mismatches = mismatches + 1;
    end
    if (out_error_position !== want.error_position) begin
      $error("error_position: expected %0d, actual %0d", want.error_position,
             out_error_position);
      mismatches = mismatches + 1;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_parse();
      expected_results.delete();
    end else begin
      if (in_push && !in_full) begin
        scan_char(in_character, in_last);
      end
      if (out_pop && !out_empty) begin
        check_result();
      end
    end
    pending <= expected_results.size();
  end

endmodule

/* tb/sv/prefixed_integer_string_parser_tb.sv */
`timescale 1ns / 1ps
module prefixed_integer_string_parser_tb;
  import pisp_pkg::*;

  localparam int CHAR_TARGET = 650;
  localparam int QUIET_FROM  = 560;
  localparam int STUCK_LIMIT = 2000;

  logic                 clk;
  logic                 rst_n;
  logic                 in_push;
  logic [CHAR_W-1:0]    in_character;
  logic                 in_last;
  logic                 in_full;
  logic                 out_empty;
  logic                 out_pop = 1'b0;
  logic [1:0]           out_status;
  logic signed [VALUE_W-1:0] out_value;
  logic [POS_W-1:0]     out_error_position;

  int mismatches;
  int pending;
  int chars_sent;
  int stuck;
  int pop_hold;
  int in_idle_pct  = 0;
  int pop_stall_pct = 0;
  bit quiet        = 1'b0;

  logic [7:0] line_buf[$];

  prefixed_integer_string_parser u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_character       (in_character),
    .in_last            (in_last),
    .in_full            (in_full),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_status         (out_status),
    .out_value          (out_value),
    .out_error_position (out_error_position)
  );

  number_parse_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_character       (in_character),
    .in_last            (in_last),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_status         (out_status),
    .out_value          (out_value),
    .out_error_position (out_error_position),
    .mismatches         (mismatches),
    .pending            (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop  <= 1'b0;
      pop_hold <= 0;
    end else if (pop_hold > 0) begin
      out_pop  <= 1'b0;
      pop_hold <= pop_hold - 1;
    end else if (!quiet && $urandom_range(0, 99) < pop_stall_pct) begin
      out_pop  <= 1'b0;
      pop_hold <= $urandom_range(0, 12);
    end else begin
      out_pop <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      stuck <= 0;
    end else begin
      stuck <= stuck + 1;
      if (stuck >= STUCK_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic push_char(input logic [7:0] c, input logic last);
    in_push      <= 1'b1;
    in_character <= c;
    in_last      <= last;
    @(posedge clk);
    while (in_full) begin
      @(posedge clk);
    end
    chars_sent = chars_sent + 1;
    if (!quiet && $urandom_range(0, 99) < in_idle_pct) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  task automatic send_line();
    for (int i = 0; i < line_buf.size(); i++) begin
      push_char(line_buf[i], i == line_buf.size() - 1);
    end
  endtask

  task automatic send_word(input string s);
    line_buf.delete();
    for (int i = 0; i < s.len(); i++) begin
      line_buf.push_back(s[i]);
    end
    send_line();
  endtask

  function automatic logic [7:0] digit_char(input int d);
    return (d < 10) ? CH_ZERO + 8'(d) : CH_A + 8'(d - 10);
  endfunction

  task automatic build_number();
    int                 base_sel;
    int                 base;
    int                 start;
    longint unsigned    mag;
    line_buf.delete();
    if ($urandom_range(0, 1)) begin
      line_buf.push_back(CH_MINUS);
    end
    base_sel = $urandom_range(0, 9);
    if (base_sel < 4) begin
      base = 10;
    end else if (base_sel < 7) begin
      base = 16;
      line_buf.push_back(CH_ZERO);
      line_buf.push_back(CH_X);
    end else if (base_sel < 9) begin
      base = 8;
      line_buf.push_back(CH_ZERO);
    end else begin
      base = 2;
      line_buf.push_back(CH_B);
    end
    case ($urandom_range(0, 4))
      0:       mag = 64'($urandom_range(0, 300));
      1:       mag = 64'($urandom);
      2:       mag = 64'd2147483647 + 64'($urandom_range(0, 2));
      3:       mag = 64'($urandom_range(0, 65535));
      default: mag = {$urandom, $urandom} >> $urandom_range(28, 40);
    endcase
    start = line_buf.size();
    if (mag == 0 && base != 8) begin
      line_buf.push_back(CH_ZERO);
    end
    while (mag != 0) begin
      line_buf.insert(start, digit_char(int'(mag % base)));
      mag = mag / base;
    end
    if (line_buf.size() > 0 && $urandom_range(0, 3) == 0) begin
      start = $urandom_range(0, line_buf.size() - 1);
      case ($urandom_range(0, 2))
        0:       line_buf[start] = 8'($urandom_range(0, 255));
        1:       line_buf.insert(start, CH_MINUS);
        default: line_buf.insert(start, 8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  task automatic build_noise();
    logic [7:0] picks[10];
    picks = '{CH_MINUS, CH_B, CH_ZERO, CH_X, CH_NINE, CH_A, CH_F, 8'h47, 8'h38, 8'h31};
    line_buf.delete();
    repeat ($urandom_range(1, 5)) begin
      if ($urandom_range(0, 1)) begin
        line_buf.push_back(picks[$urandom_range(0, 9)]);
      end else begin
        line_buf.push_back(8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    in_push      = 1'b0;
    in_character = '0;
    in_last      = 1'b0;
    rst_n        = 1'b0;
    chars_sent   = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    in_idle_pct   = 20;
    pop_stall_pct = 20;
    send_word("b");
    send_word("0x");
    send_word("-");
    send_word("-0x");
    send_word("0");
    send_word("-0");
    send_word("--5");
    send_word("0x1F");
    send_word("b12");
    send_word("08");
    push_char(8'h00, 1'b1);
    push_char(8'hFF, 1'b1);

    while (chars_sent < CHAR_TARGET) begin
      if (chars_sent >= QUIET_FROM) begin
        quiet = 1'b1;
      end else if ($urandom_range(0, 7) == 0) begin
        in_idle_pct   = $urandom_range(0, 2) * 20;
        pop_stall_pct = $urandom_range(0, 2) * 20;
      end
      if (chars_sent > 150 && chars_sent < 190) begin
        // A string past the index ceiling, with a bad character at its end.
        line_buf.delete();
        line_buf.push_back(CH_ZERO);
        repeat (260) line_buf.push_back(8'h37);
        line_buf.push_back(8'h47);
      end else if ($urandom_range(0, 4) == 0) begin
        build_noise();
      end else begin
        build_number();
      end
      send_line();
    end

    in_push <= 1'b0;
    @(posedge clk);
    while (pending != 0) begin
      @(posedge clk);
    end
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* files.f */
design/pisp_pkg.sv
design/pisp_queue.sv
design/pisp_front.sv
design/pisp_back.sv
design/prefixed_integer_string_parser.sv
tb/sv/number_parse_checker.sv
tb/sv/prefixed_integer_string_parser_tb.sv
